// File: rtl/core/rtcm_pkg.sv
package rtcm_pkg;

  // default number of entries in each range table
  localparam int unsigned TableDepthDefault = 1024;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned RangeW = 31;
  localparam int unsigned IndexW = 10;
  localparam int unsigned CountW = 11;
  localparam int unsigned CfgIdxW = 1;

  // table entry layout in memory: {base, high, low}
  localparam int unsigned EntryW = CodeW + 2 * RangeW;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegLowerCount = 1'b0;
  localparam logic [CfgIdxW-1:0] RegUpperCount = 1'b1;

  // item kinds
  localparam logic KindLoad = 1'b0;
  localparam logic KindMap  = 1'b1;

  // table select codes
  localparam logic TblLower = 1'b0;
  localparam logic TblUpper = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic                     table_select;
    logic [IndexW-1:0]        entry_index;
    logic [RangeW-1:0]        range_low;
    logic [RangeW-1:0]        range_high;
    logic signed [CodeW-1:0]  range_base;
    logic signed [CodeW-1:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic signed [CodeW-1:0]  mapped_code;
    logic                     range_hit;
  } out_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  base;
    logic [RangeW-1:0] high;
    logic [RangeW-1:0] low;
  } entry_t;

endpackage

// File: rtl/core/range_table_character_map.sv
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+--------------------------
// in       | input     | in_valid_i / in_ready_o | in_item_i (load or map)
// out      | output    | out_valid_o/out_ready_i | out_item_o (map results)
// cfg      | input     | cfg_we_i, no wait       | cfg_idx_i, cfg_wdata_i
//
// a load item leaves the block idle and ready for another item; a map item makes p
// probes, at most floor(log2(count)) + 1, so 11 probes at 1024 ranges, then finishes
// each probe is one registered table read plus one compare that steers the next address
// reset clears the range counts and the control state; table contents stay undefined
// a finished result waits in the output register while the block takes the next item;
// a map item stalls on its last cycle only while the previous result is still waiting
module range_table_character_map #(
  parameter int unsigned TABLE_DEPTH = rtcm_pkg::TableDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rtcm_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output rtcm_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [rtcm_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [rtcm_pkg::CountW-1:0]         cfg_wdata_i
);

  import rtcm_pkg::*;

  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CmpW = AddrW + 2;
  localparam int unsigned CountMax = (1 << CountW) - 1;
  localparam int unsigned DepthClamp = (TABLE_DEPTH < CountMax) ? TABLE_DEPTH : CountMax;
  localparam int unsigned WideW = (CmpW > CountW + 1) ? CmpW : CountW + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CountW-1:0] lower_cnt_q, upper_cnt_q;
  logic [CountW-1:0] start_q, start_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CountW-1:0] probe_q, probe_d;
  logic              sel_q, sel_d;
  logic [CodeW-1:0]  code_q, code_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic [EntryW-1:0] lower_mem [TABLE_DEPTH];
  logic [EntryW-1:0] upper_mem [TABLE_DEPTH];
  logic [EntryW-1:0] lower_rd_q, upper_rd_q;

  logic              in_acc;
  logic              load_ok;
  logic              wr_lower, wr_upper;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic              rd_en;
  logic [EntryW-1:0] wr_data;
  logic [CountW-1:0] sel_cnt, clamp_cnt;
  entry_t            ent;
  logic [RangeW-1:0] code_r;
  logic              above, hit;
  logic [CountW-1:0] start_n, len_m, len_n, probe_n;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // table writes
  assign load_ok  = (WideW'(in_item_i.entry_index) < WideW'(TABLE_DEPTH));
  assign wr_lower = in_acc && (in_item_i.kind == KindLoad) && load_ok &&
                    (in_item_i.table_select == TblLower);
  assign wr_upper = in_acc && (in_item_i.kind == KindLoad) && load_ok &&
                    (in_item_i.table_select == TblUpper);
  assign wr_addr  = AddrW'(in_item_i.entry_index);
  assign wr_data  = {in_item_i.range_base, in_item_i.range_high, in_item_i.range_low};
  assign rd_addr  = AddrW'(probe_d);

  always_ff @(posedge clk_i) begin
    if (wr_lower) begin
      lower_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      lower_rd_q <= lower_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_upper) begin
      upper_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      upper_rd_q <= upper_mem[rd_addr];
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_cnt_q <= '0;
      upper_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegLowerCount: lower_cnt_q <= cfg_wdata_i;
        RegUpperCount: upper_cnt_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sel_cnt   = (in_item_i.table_select == TblUpper) ? upper_cnt_q : lower_cnt_q;
  assign clamp_cnt = (WideW'(sel_cnt) > WideW'(TABLE_DEPTH)) ? CountW'(DepthClamp) : sel_cnt;

  // probe evaluation
  assign ent     = entry_t'((sel_q == TblUpper) ? upper_rd_q : lower_rd_q);
  assign code_r  = code_q[RangeW-1:0];
  assign above   = code_r > ent.high;
  assign hit     = (ent.low <= code_r) && !above;
  assign start_n = above ? (probe_q + CountW'(1)) : start_q;
  assign len_m   = above ? (len_q - CountW'(1)) : len_q;
  assign len_n   = len_m >> 1;
  assign probe_n = start_n + (len_n >> 1);

  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    len_d       = len_q;
    probe_d     = probe_q;
    sel_d       = sel_q;
    code_d      = code_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_item_i.kind == KindMap)) begin
          sel_d   = in_item_i.table_select;
          code_d  = in_item_i.char_code;
          start_d = '0;
          len_d   = clamp_cnt;
          probe_d = clamp_cnt >> 1;
          res_d.mapped_code = in_item_i.char_code;
          res_d.range_hit   = 1'b0;
          // negative codes and empty tables skip the search
          if (in_item_i.char_code[CodeW-1] || (clamp_cnt == '0)) begin
            state_d = ST_FINISH;
          end else begin
            rd_en   = 1'b1;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (hit) begin
          res_d.mapped_code = ent.base + {1'b0, code_r} - {1'b0, ent.low};
          res_d.range_hit   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          start_d = start_n;
          len_d   = len_n;
          probe_d = probe_n;
          if (len_n == '0) begin
            state_d = ST_FINISH;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    len_q   <= len_d;
    probe_q <= probe_d;
    sel_q   <= sel_d;
    code_q  <= code_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import rtcm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 20;
  localparam int ItemTarget = 750;

  // predictor of both range tables plus the queue of lookup results still owed
  class case_map_scoreboard;
    entry_t            ranges[2][TableDepthDefault];
    logic [CountW-1:0] range_count[2];
    out_item_t         pending_maps[$];
    int                failures;

    function new();
      range_count[TblLower] = '0;
      range_count[TblUpper] = '0;
      failures = 0;
    endfunction

    function void set_count(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] value);
      case (idx)
        RegLowerCount: begin
          range_count[TblLower] = value;
        end
        RegUpperCount: begin
          range_count[TblUpper] = value;
        end
        default: begin
        end
      endcase
    endfunction

    function out_item_t map_code(logic sel, logic [CodeW-1:0] code);
      out_item_t   r;
      entry_t      e;
      int unsigned start;
      int unsigned len;
      int unsigned probe;
      r.mapped_code = code;
      r.range_hit = 1'b0;
      if (code[CodeW-1]) return r;
      start = 0;
      len = (range_count[sel] > TableDepthDefault) ? TableDepthDefault : range_count[sel];
      while (len != 0) begin
        probe = start + (len >> 1);
        if (probe >= TableDepthDefault) break;
        e = ranges[sel][probe];
        if (e.low <= code && code <= e.high) begin
          r.mapped_code = e.base + code - e.low;
          r.range_hit = 1'b1;
          return r;
        end
        // past the probed range: continue in the upper half
        if (code > e.high) begin
          start = probe + 1;
          len--;
        end
        len = len >> 1;
      end
      return r;
    endfunction

    function void note_input(in_item_t it);
      entry_t e;
      if (it.kind == KindLoad) begin
        e.low = it.range_low;
        e.high = it.range_high;
        e.base = it.range_base;
        ranges[it.table_select][it.entry_index] = e;
      end else begin
        pending_maps.push_back(map_code(it.table_select, it.char_code));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_maps.size() == 0) begin
        $error("result with no lookup pending: mapped_code %h range_hit %b",
               got.mapped_code, got.range_hit);
        failures++;
        return;
      end
      exp = pending_maps.pop_front();
      if (got.mapped_code !== exp.mapped_code) begin
        $error("mapped_code: expected %h, got %h", exp.mapped_code, got.mapped_code);
        failures++;
      end
      if (got.range_hit !== exp.range_hit) begin
        $error("range_hit: expected %b, got %b", exp.range_hit, got.range_hit);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_ready;
  out_item_t         out_item;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CountW-1:0] cfg_wdata;

  case_map_scoreboard sb = new();
  bit sender_steady = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;

  range_table_character_map dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5ns clk = 1'b1;
    #5ns clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t load_item(logic sel, logic [IndexW-1:0] idx,
                                         logic [RangeW-1:0] lo, logic [RangeW-1:0] hi,
                                         logic [CodeW-1:0] base);
    in_item_t it;
    it.kind = KindLoad;
    it.table_select = sel;
    it.entry_index = idx;
    it.range_low = lo;
    it.range_high = hi;
    it.range_base = base;
    it.char_code = $urandom;
    return it;
  endfunction

  function automatic in_item_t map_item(logic sel, logic [CodeW-1:0] code);
    in_item_t it;
    it.kind = KindMap;
    it.table_select = sel;
    it.entry_index = IndexW'($urandom);
    it.range_low = RangeW'($urandom);
    it.range_high = RangeW'($urandom);
    it.range_base = $urandom;
    it.char_code = code;
    return it;
  endfunction

  function automatic int random_count();
    case ($urandom_range(0, 7))
      0: begin
        return 0;
      end
      1: begin
        return 1;
      end
      2: begin
        return $urandom_range(2, 3);
      end
      default: begin
        return $urandom_range(4, 40);
      end
    endcase
  endfunction

  // hits inside a range, codes just outside one, and arbitrary codes;
  // a spine table only holds entries n/2, n/4, .. 0
  function automatic logic [CodeW-1:0] pick_code(logic sel, int n, bit spine);
    entry_t            e;
    logic [CodeW-1:0]  code;
    int                mode;
    mode = (n == 0) ? $urandom_range(0, 1) : $urandom_range(0, 5);
    if (n != 0) begin
      e = sb.ranges[sel][spine ? (n >> $urandom_range(1, 11)) : $urandom_range(0, n - 1)];
    end
    case (mode)
      0: begin
        code = $urandom;
      end
      1: begin
        code = {1'b0, RangeW'($urandom)};
      end
      4: begin
        code = {1'b0, e.low} - 32'd1;
      end
      5: begin
        code = {1'b0, e.high} + 32'd1;
      end
      default: begin
        if (e.low <= e.high) begin
          code = {1'b0, e.low} + ($urandom % ({1'b0, e.high} - {1'b0, e.low} + 32'd1));
        end else begin
          code = {1'b0, e.low};
        end
      end
    endcase
    return code;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_maps.size() != 0);
  endtask

  // a load item may still be in flight after the last result
  task automatic settle_idle();
    wait_results();
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_count(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    sb.set_count(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ascending, non-overlapping ranges in entries 0 .. n-1
  task automatic load_sorted_table(logic sel, int n);
    longint unsigned cursor;
    longint unsigned lo;
    longint unsigned hi;
    int unsigned     step;
    step = 32'h3fff_ffff / n;
    case ($urandom_range(0, 2))
      0: begin
        if (step > 40) step = 40;
      end
      1: begin
        if (step > 5000) step = 5000;
      end
      default: begin
      end
    endcase
    cursor = $urandom_range(0, step);
    for (int i = 0; i < n; i++) begin
      lo = cursor + $urandom_range(0, step);
      hi = lo + $urandom_range(0, step);
      if (i == n - 1 && $urandom_range(0, 3) == 0) hi = 32'h7fff_ffff;
      if (lo > 32'h7fff_ffff) lo = 32'h7fff_ffff;
      if (hi > 32'h7fff_ffff) hi = 32'h7fff_ffff;
      cursor = hi + 1;
      send_item(load_item(sel, IndexW'(i), RangeW'(lo), RangeW'(hi), $urandom));
    end
  endtask

  // lows fall with the entry position and every high is the top code, so a search
  // never moves up and only probes entries n/2, n/4, .. 0
  task automatic load_spine_table(logic sel, int n);
    longint unsigned cursor;
    int unsigned     step;
    int              len;
    step = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40)
                                       : $urandom_range(41, 32'h07ff_ffff);
    cursor = longint'(step) * 12 + $urandom_range(0, step);
    len = n;
    while (len != 0) begin
      send_item(load_item(sel, IndexW'(len >> 1), RangeW'(cursor), {RangeW{1'b1}},
                          $urandom));
      cursor = cursor - $urandom_range(1, step);
      len = len >> 1;
    end
  endtask

  initial begin : result_sink
    int stall;
    int steady_left;
    out_ready = 1'b0;
    steady_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (steady_left > 0) begin
        stall = 0;
        steady_left--;
      end else begin
        if ($urandom_range(0, 15) == 0) steady_left = $urandom_range(5, 30);
        stall = $urandom_range(0, 7);
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
    end
  end

  initial begin : stimulus
    int   phase;
    int   lookups;
    int   count_set[2];
    int   span_len[2];
    int   filled[2];
    bit   spine_mode[2];
    logic sel;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty tables: only misses and the negative-code bypass
    send_item(map_item(TblLower, 32'd0));
    send_item(map_item(TblUpper, 32'h7fff_ffff));
    send_item(map_item(TblLower, 32'h8000_0000));
    settle_idle();
    write_count(RegLowerCount, 11'd3);
    write_count(RegUpperCount, 11'd2);
    send_item(load_item(TblLower, 10'd0, 31'd10, 31'd20, 32'd100));
    send_item(load_item(TblLower, 10'd1, 31'd30, 31'd40, 32'hffff_fffb));
    send_item(load_item(TblLower, 10'd2, 31'd50, 31'h7fff_ffff, 32'h7fff_ffff));
    // whole non-negative code space, then an inverted range probed first
    send_item(load_item(TblUpper, 10'd0, 31'd0, 31'h7fff_ffff, 32'h8000_0000));
    send_item(load_item(TblUpper, 10'd1, 31'd100, 31'd5, 32'd7));
    send_item(load_item(TblUpper, 10'd1023, 31'h7fff_ffff, 31'h7fff_ffff, 32'hffff_ffff));
    send_item(map_item(TblLower, 32'd15));
    send_item(map_item(TblLower, 32'd25));
    send_item(map_item(TblLower, 32'd30));
    send_item(map_item(TblLower, 32'h7fff_ffff));
    send_item(map_item(TblLower, 32'd5));
    send_item(map_item(TblLower, 32'hffff_ffff));
    send_item(map_item(TblUpper, 32'd50));
    send_item(map_item(TblUpper, 32'd3));
    filled[TblLower] = 3;
    filled[TblUpper] = 2;

    phase = 0;
    while (items_sent < ItemTarget || phase < 3) begin
      settle_idle();
      case (phase)
        0: begin
          count_set[TblLower] = 1024;
          count_set[TblUpper] = random_count();
        end
        1: begin
          count_set[TblLower] = 0;
          count_set[TblUpper] = 0;
        end
        2: begin
          // counts above the table depth
          count_set[TblLower] = $urandom_range(1025, 2047);
          count_set[TblUpper] = 2047;
        end
        default: begin
          count_set[TblLower] = random_count();
          count_set[TblUpper] = random_count();
        end
      endcase
      write_count(RegLowerCount, CountW'(count_set[TblLower]));
      write_count(RegUpperCount, CountW'(count_set[TblUpper]));
      sender_steady = ($urandom_range(0, 3) == 0);
      for (int s = 0; s < 2; s++) begin
        span_len[s] = (count_set[s] > 1024) ? 1024 : count_set[s];
        spine_mode[s] = (span_len[s] > 64);
        if (spine_mode[s]) begin
          load_spine_table(1'(s), span_len[s]);
        end else if (span_len[s] > filled[s] ||
                     (span_len[s] != 0 && $urandom_range(0, 1) == 1)) begin
          load_sorted_table(1'(s), span_len[s]);
          if (span_len[s] > filled[s]) filled[s] = span_len[s];
        end
      end
      lookups = (phase < 3) ? 60 : $urandom_range(10, 40);
      for (int i = 0; i < lookups; i++) begin
        sel = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
          // stray write anywhere, ranges unsorted or inverted;
          // on a spine table the high stays at the top code
          send_item(load_item(sel, IndexW'($urandom), RangeW'($urandom),
                              spine_mode[sel] ? {RangeW{1'b1}} : RangeW'($urandom),
                              $urandom));
        end else begin
          send_item(map_item(sel, pick_code(sel, span_len[sel], spine_mode[sel])));
        end
        if ($urandom_range(0, 49) == 0) wait_results();
      end
      phase++;
    end

    settle_idle();
    if (sb.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
